@@ rtl/mksl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mksl_pkg
// Shared types and constants for the multi-key short/long press detector.
// ----------------------------------------------------------------------------
package mksl_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int THRESH_W    = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CONFIRM_TICKS    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_TICKS       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_LEVELS    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_ON_RELEASE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_ON_RELEASE  = 3'd4;

    localparam logic [THRESH_W-1:0] CONFIRM_TICKS_RST = 16'd20;
    localparam logic [THRESH_W-1:0] LONG_TICKS_RST    = 16'd1500;

    typedef enum logic [1:0] {
        PH_RELEASED = 2'd0,
        PH_CONFIRM  = 2'd1,
        PH_SHORT    = 2'd2,
        PH_LONG     = 2'd3
    } t_key_phase;

    // Settings shared by every key lane
    typedef struct packed {
        logic [THRESH_W-1:0] confirm_ticks;
        logic [THRESH_W-1:0] long_ticks;
        logic                short_on_release;
        logic                long_on_release;
    } t_lane_cfg;

    // Event pulses of one lane for the current word
    typedef struct packed {
        logic short_evt;
        logic long_evt;
    } t_lane_evt;

endpackage

@@ rtl/mksl_key_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mksl_key_lane
// Press state machine and saturating press counter of a single key.
// ----------------------------------------------------------------------------
module mksl_key_lane #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic                i_pressed,
    input  mksl_pkg::t_lane_cfg i_cfg,
    output mksl_pkg::t_lane_evt o_evt
);
    import mksl_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;

    t_key_phase             r_phase;
    t_key_phase             n_phase;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [COUNT_WIDTH-1:0] w_count_inc;
    logic [CMP_W-1:0]       w_count_ext;
    logic                   w_over_confirm;
    logic                   w_over_long;

    // Saturating increment
    assign w_count_inc = (&r_count) ? r_count : r_count + 1'b1;
    assign w_count_ext = CMP_W'(w_count_inc);
    assign w_over_confirm = w_count_ext > CMP_W'(i_cfg.confirm_ticks);
    assign w_over_long    = w_count_ext > CMP_W'(i_cfg.long_ticks);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RELEASED;
            r_count <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_count         = r_count;
        o_evt.short_evt = 1'b0;
        o_evt.long_evt  = 1'b0;
        unique case (r_phase)
            PH_RELEASED: begin
                // The counter is only cleared here, so a bouncing key keeps
                // its earlier pressed ticks.
                if (i_pressed) begin
                    n_phase = PH_CONFIRM;
                end else begin
                    n_count = '0;
                end
            end
            PH_CONFIRM: begin
                if (i_pressed) begin
                    n_count = w_count_inc;
                    if (w_over_confirm) begin
                        n_phase         = PH_SHORT;
                        o_evt.short_evt = !i_cfg.short_on_release;
                    end
                end else begin
                    n_phase = PH_RELEASED;
                end
            end
            PH_SHORT: begin
                if (i_pressed) begin
                    n_count = w_count_inc;
                    if (w_over_long) begin
                        n_phase        = PH_LONG;
                        o_evt.long_evt = !i_cfg.long_on_release;
                    end
                end else begin
                    n_phase         = PH_RELEASED;
                    o_evt.short_evt = i_cfg.short_on_release;
                end
            end
            PH_LONG: begin
                if (!i_pressed) begin
                    n_phase        = PH_RELEASED;
                    o_evt.long_evt = i_cfg.long_on_release;
                end
            end
        endcase
    end

endmodule

@@ rtl/mksl_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mksl_merge
// Gathers the lane events into one result word and holds it in the output
// register until the downstream side takes it.
// ----------------------------------------------------------------------------
module mksl_merge #(
    parameter int NUM_KEYS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  mksl_pkg::t_lane_evt [NUM_KEYS-1:0]  i_lane_evt,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic                                o_busy,
    output logic [NUM_KEYS-1:0]                 o_short_events,
    output logic [NUM_KEYS-1:0]                 o_long_events
);
    import mksl_pkg::*;

    logic                r_valid;
    logic [NUM_KEYS-1:0] r_short;
    logic [NUM_KEYS-1:0] r_long;
    logic [NUM_KEYS-1:0] w_short;
    logic [NUM_KEYS-1:0] w_long;

    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            w_short[k] = i_lane_evt[k].short_evt;
            w_long[k]  = i_lane_evt[k].long_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_short <= w_short;
            r_long  <= w_long;
        end
    end

    // A new word may enter when the register is empty or the held one leaves in the same cycle.
    assign o_busy         = r_valid && i_stall;
    assign o_valid        = r_valid;
    assign o_short_events = r_short;
    assign o_long_events  = r_long;

endmodule

@@ rtl/multi_key_short_long_press_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_key_short_long_press_top
// Each key has its own lane; a word's result shows in the cycle after the word
// is accepted. Throughput: one scan word per cycle unless the output stalls;
// the output register frees in the same cycle that its word is taken.
// Reset (synchronous, active low) returns every key to released with a zero
// counter, empties the output register and loads the register defaults.
// ----------------------------------------------------------------------------
module multi_key_short_long_press_top #(
    parameter int NUM_KEYS    = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [NUM_KEYS-1:0]              i_raw_levels,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [NUM_KEYS-1:0]              o_short_events,
    output logic [NUM_KEYS-1:0]              o_long_events,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mksl_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [mksl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mksl_pkg::*;

    logic [THRESH_W-1:0]             r_confirm_ticks;
    logic [THRESH_W-1:0]             r_long_ticks;
    logic [NUM_KEYS-1:0]             r_active_levels;
    logic                            r_short_on_release;
    logic                            r_long_on_release;
    logic                            w_fire;
    logic                            w_busy;
    logic                            w_cfg_wr;
    logic [NUM_KEYS-1:0]             w_pressed;
    t_lane_cfg                       w_lane_cfg;
    t_lane_evt [NUM_KEYS-1:0]        w_lane_evt;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_confirm_ticks    <= CONFIRM_TICKS_RST;
            r_long_ticks       <= LONG_TICKS_RST;
            r_active_levels    <= '0;
            r_short_on_release <= 1'b1;
            r_long_on_release  <= 1'b1;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                CFG_CONFIRM_TICKS:    r_confirm_ticks    <= i_cfg_data[THRESH_W-1:0];
                CFG_LONG_TICKS:       r_long_ticks       <= i_cfg_data[THRESH_W-1:0];
                CFG_ACTIVE_LEVELS:    r_active_levels    <= i_cfg_data[NUM_KEYS-1:0];
                CFG_SHORT_ON_RELEASE: r_short_on_release <= i_cfg_data[0];
                CFG_LONG_ON_RELEASE:  r_long_on_release  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_lane_cfg.confirm_ticks    = r_confirm_ticks;
    assign w_lane_cfg.long_ticks       = r_long_ticks;
    assign w_lane_cfg.short_on_release = r_short_on_release;
    assign w_lane_cfg.long_on_release  = r_long_on_release;

    assign o_stall   = w_busy;
    assign w_fire    = i_valid && !w_busy;
    // A key is pressed when its pin matches its active level.
    assign w_pressed = ~(i_raw_levels ^ r_active_levels);

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        mksl_key_lane #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_fire   (w_fire),
            .i_pressed(w_pressed[k]),
            .i_cfg    (w_lane_cfg),
            .o_evt    (w_lane_evt[k])
        );
    end

    mksl_merge #(
        .NUM_KEYS(NUM_KEYS)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_fire),
        .i_lane_evt    (w_lane_evt),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_busy        (w_busy),
        .o_short_events(o_short_events),
        .o_long_events (o_long_events)
    );

endmodule
